// ----- design/enms_pkg.sv -----
package enms_pkg;

  localparam int MAG_W         = 16;
  localparam int ANGLE_W       = 16;
  localparam int CFG_W         = 11;
  localparam int CFG_INDEX_W   = 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;

  // output queue between the pipeline and the result channel
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // one line store entry: angle of the middle row, magnitudes of upper and middle rows
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [MAG_W-1:0]   upper;
    logic [MAG_W-1:0]   middle;
  } line_entry_t;

  localparam int ENTRY_W = $bits(line_entry_t);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude_out;
    logic             last;
  } result_t;

endpackage

// ----- design/enms_if.sv -----
interface enms_pixel_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic        [enms_pkg::MAG_W-1:0]    magnitude;
  logic signed [enms_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, op, magnitude, angle, input ready);
  modport sink   (input valid, op, magnitude, angle, output ready);
endinterface

interface enms_result_if;
  logic                          valid;
  logic                          ready;
  logic [enms_pkg::MAG_W-1:0]    magnitude_out;
  logic                          last;

  modport source (output valid, magnitude_out, last, input ready);
  modport sink   (input valid, magnitude_out, last, output ready);
endinterface

// ----- design/edge_non_maximum_suppression_top.sv -----
// Non-maximum suppression for a Canny edge path.
// pixel channel: one beat per pixel in raster order (x fastest), op = pixel,
//   magnitude and binary angle (32768 = pi); op = drain flushes one pending
//   result once the whole image is in. Send width+1 drains after each image.
// result channel: suppressed magnitude, last marks the final pixel of the image.
// Each result belongs to the pixel width+1 beats earlier; border pixels pass.
// An accepted beat is registered in the read-data stage, then in the output queue.
// Throughput: one beat per cycle while the output queue has room. The line store is
//   one RAM read in the accept cycle and written in the next, so pixels never wait on it.
// The user writes configuration (cfg_write, cfg_index, cfg_data) only while idle;
//   the block does not check it. Width and height are clamped to [3, MAX_WIDTH] and
//   [3, 1024] and restart the image. Reset clears the counters and the output queue.
//   The line store is not cleared and needs no clearing pass: every entry is written
//   before it matters. A stalled receiver fills a four-beat output queue; ready drops
//   when the queue and the pipeline slot together have no room left.
module edge_non_maximum_suppression_top #(
  parameter int MAX_WIDTH = enms_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  enms_pixel_if.sink                        pixel,
  enms_result_if.source                     result,
  input  logic                              cfg_write,
  input  logic [enms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [enms_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(enms_pkg::MAX_HEIGHT + 1);
  localparam int CNT_W   = $clog2(MAX_WIDTH * enms_pkg::MAX_HEIGHT + 1);
  localparam int CMP_W   = (WW > enms_pkg::CFG_W) ? WW : enms_pkg::CFG_W;
  localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int T_RESET = W_RESET * enms_pkg::MAX_HEIGHT;
  localparam int MAG_W   = enms_pkg::MAG_W;
  localparam int FC_W    = enms_pkg::FIFO_CNT_W;
  localparam int FP_W    = enms_pkg::FIFO_PTR_W;

  localparam logic signed [15:0] BA_PI_8  = 16'sd4096;
  localparam logic signed [15:0] BA_3PI_8 = 16'sd12288;
  localparam logic signed [15:0] BA_5PI_8 = 16'sd20480;
  localparam logic signed [15:0] BA_7PI_8 = 16'sd28672;

  typedef enum logic [1:0] {SECTOR_A, SECTOR_B, SECTOR_C, SECTOR_D} sector_t;

  function automatic sector_t angle_sector(logic signed [15:0] a);
    sector_t s;
    if ((a > -BA_PI_8 && a <= BA_PI_8) || a > BA_7PI_8 || a <= -BA_7PI_8) begin
      s = SECTOR_A;
    end else if ((a > -BA_5PI_8 && a <= -BA_3PI_8) || (a > BA_3PI_8 && a <= BA_5PI_8)) begin
      s = SECTOR_B;
    end else if ((a > -BA_3PI_8 && a <= -BA_PI_8) || (a > BA_5PI_8 && a <= BA_7PI_8)) begin
      s = SECTOR_C;
    end else begin
      s = SECTOR_D;
    end
    return s;
  endfunction

  // configuration and position state
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [CNT_W-1:0] total;
  logic [AW-1:0]    column_count;
  logic [HW-1:0]    row_count;
  logic [CNT_W-1:0] emitted_count;

  // config clamp
  logic [CMP_W-1:0] cfg_wide;
  logic [WW-1:0]    w_clamped;
  logic [HW-1:0]    h_clamped;
  logic [WW-1:0]    w_sel;
  logic [HW-1:0]    h_sel;
  logic             cfg_hit;

  assign cfg_wide  = CMP_W'(cfg_data);
  assign w_clamped = (cfg_wide < CMP_W'(3)) ? WW'(3) :
                     (cfg_wide > CMP_W'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_wide);
  assign h_clamped = (cfg_data < enms_pkg::CFG_W'(3)) ? HW'(3) :
                     (cfg_data > enms_pkg::CFG_W'(enms_pkg::MAX_HEIGHT)) ?
                     HW'(enms_pkg::MAX_HEIGHT) : HW'(cfg_data);

  always_comb begin
    w_sel   = w_eff;
    h_sel   = h_eff;
    cfg_hit = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        enms_pkg::REG_IMAGE_WIDTH: begin
          w_sel   = w_clamped;
          cfg_hit = 1'b1;
        end
        enms_pkg::REG_IMAGE_HEIGHT: begin
          h_sel   = h_clamped;
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // accept stage
  logic             acc;
  logic             is_pixel;
  logic             restart;
  logic [AW-1:0]    x;
  logic [HW-1:0]    y;
  logic [CNT_W-1:0] e_base;
  logic [WW-1:0]    w_minus1;
  logic             x_last;
  logic             pix_emit;
  logic             pix_suppress;
  logic [CNT_W:0]   total_ext;
  logic [CNT_W:0]   drain_sum;
  logic [CNT_W:0]   drain_diff;
  logic             drain_emit;
  logic             drain_upper;
  logic             drain_last;
  logic [AW-1:0]    drain_idx;
  logic [AW-1:0]    rd_addr;

  assign acc      = pixel.valid && pixel.ready;
  assign is_pixel = (pixel.op == enms_pkg::OP_PIXEL);
  assign restart  = (row_count >= h_eff) || (WW'(column_count) >= w_eff);
  assign x        = restart ? '0 : column_count;
  assign y        = restart ? '0 : row_count;
  assign e_base   = restart ? '0 : emitted_count;
  assign w_minus1 = w_eff - WW'(1);
  assign x_last   = (WW'(x) == w_minus1);
  // pixel index y*w+x reaches w+1 from (1,1) on
  assign pix_emit     = (y >= HW'(2)) || ((y == HW'(1)) && (x != '0));
  assign pix_suppress = (x >= AW'(2)) && (y >= HW'(2));

  assign total_ext   = (CNT_W+1)'(total);
  assign drain_sum   = (CNT_W+1)'(emitted_count) + (CNT_W+1)'(w_eff) + (CNT_W+1)'(1);
  assign drain_diff  = (CNT_W+1)'(emitted_count) + (CNT_W+1)'(w_eff) - total_ext;
  assign drain_emit  = (row_count >= h_eff) && (emitted_count < total) &&
                       (drain_sum >= total_ext);
  assign drain_upper = (drain_sum == total_ext);
  assign drain_last  = ((CNT_W+1)'(emitted_count) + (CNT_W+1)'(1) == total_ext);
  // column of the last row still pending, below the width whenever a drain emits from it
  assign drain_idx   = drain_diff[AW-1:0];
  assign rd_addr     = is_pixel ? x : (drain_upper ? w_minus1[AW-1:0] : drain_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff         <= WW'(W_RESET);
      h_eff         <= HW'(enms_pkg::MAX_HEIGHT);
      total         <= CNT_W'(T_RESET);
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
    end else if (cfg_hit) begin
      w_eff         <= w_sel;
      h_eff         <= h_sel;
      total         <= CNT_W'(w_sel) * CNT_W'(h_sel);
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
    end else if (acc) begin
      if (is_pixel) begin
        column_count  <= x_last ? '0 : x + AW'(1);
        row_count     <= x_last ? y + HW'(1) : y;
        emitted_count <= e_base + CNT_W'(pix_emit);
      end else if (drain_emit) begin
        if (drain_last) begin
          column_count  <= '0;
          row_count     <= '0;
          emitted_count <= '0;
        end else begin
          emitted_count <= emitted_count + CNT_W'(1);
        end
      end
    end
  end

  // beat in the read-data stage
  logic             s1_valid;
  logic             s1_pixel;
  logic             s1_emit;
  logic             s1_suppress;
  logic             s1_upper;
  logic             s1_last;
  logic [MAG_W-1:0] s1_mag;
  logic [15:0]      s1_ang;
  logic [AW-1:0]    s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
    if (acc) begin
      s1_pixel    <= is_pixel;
      s1_emit     <= is_pixel ? pix_emit : drain_emit;
      s1_suppress <= pix_suppress;
      s1_upper    <= drain_upper;
      s1_last     <= !is_pixel && drain_last;
      s1_mag      <= pixel.magnitude;
      s1_ang      <= pixel.angle;
      s1_addr     <= rd_addr;
    end
  end

  // line store with write-to-read forwarding
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  enms_pkg::line_entry_t ram_wdata;
  enms_pkg::line_entry_t ram_rdata;
  enms_pkg::line_entry_t fwd_data;
  logic                  fwd_hit;
  enms_pkg::line_entry_t rd;

  assign rd        = fwd_hit ? fwd_data : ram_rdata;
  assign ram_we    = s1_valid && s1_pixel;
  assign ram_waddr = s1_addr;
  assign ram_wdata = '{angle: s1_ang, upper: rd.middle, middle: s1_mag};

  enms_ram #(
    .WIDTH (enms_pkg::ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (ram_waddr == rd_addr);
    end
    fwd_data <= ram_wdata;
  end

  // 3x3 window: rows upper/middle/lower, column 2 is the newest
  logic [MAG_W-1:0] window      [9];
  logic [MAG_W-1:0] window_next [9];
  logic [15:0]      centre_angle;
  sector_t          sector;
  logic [MAG_W-1:0] n1;
  logic [MAG_W-1:0] n2;
  logic [MAG_W-1:0] centre;
  logic [MAG_W-1:0] pix_result;
  logic [MAG_W-1:0] drain_result;

  always_comb begin
    window_next[0] = window[1];
    window_next[1] = window[2];
    window_next[2] = rd.upper;
    window_next[3] = window[4];
    window_next[4] = window[5];
    window_next[5] = rd.middle;
    window_next[6] = window[7];
    window_next[7] = window[8];
    window_next[8] = s1_mag;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_pixel) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= window_next[i];
      end
      centre_angle <= rd.angle;
    end
  end

  assign sector = angle_sector($signed(centre_angle));
  assign centre = window_next[4];

  always_comb begin
    case (sector)
      SECTOR_A: begin
        n1 = window_next[1];
        n2 = window_next[7];
      end
      SECTOR_B: begin
        n1 = window_next[3];
        n2 = window_next[5];
      end
      SECTOR_C: begin
        n1 = window_next[6];
        n2 = window_next[2];
      end
      default: begin
        n1 = window_next[8];
        n2 = window_next[0];
      end
    endcase
  end

  // drop an interior centre if either neighbor along the gradient is larger
  assign pix_result   = (s1_suppress && (centre < n1 || centre < n2)) ? '0 : centre;
  assign drain_result = s1_upper ? rd.upper : rd.middle;

  // output queue
  enms_pkg::result_t fifo_mem [enms_pkg::FIFO_DEPTH];
  logic [FP_W-1:0]   wptr;
  logic [FP_W-1:0]   rptr;
  logic [FC_W-1:0]   fifo_count;
  logic              push;
  logic              pop;
  logic [FC_W:0]     claimed;

  assign push    = s1_valid && s1_emit;
  assign pop     = result.valid && result.ready;
  assign claimed = (FC_W+1)'(fifo_count) + (FC_W+1)'(push);

  assign pixel.ready          = (claimed < (FC_W+1)'(enms_pkg::FIFO_DEPTH));
  assign result.valid         = (fifo_count != '0);
  assign result.magnitude_out = fifo_mem[rptr].magnitude_out;
  assign result.last          = fifo_mem[rptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FP_W'(enms_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + FP_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == FP_W'(enms_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + FP_W'(1);
      end
      fifo_count <= fifo_count + FC_W'(push) - FC_W'(pop);
    end
    if (push) begin
      fifo_mem[wptr] <= '{magnitude_out: s1_pixel ? pix_result : drain_result,
                          last: s1_last};
    end
  end

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FC_W'(enms_pkg::FIFO_DEPTH))
    else $error("output queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fifo_count < FC_W'(enms_pkg::FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    WW'(column_count) < w_eff)
    else $error("column count outside the image width");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last) |->
      (column_count == '0 && row_count == '0 && emitted_count == '0))
    else $error("final result did not restart the image");
`endif

endmodule

// ----- design/enms_ram.sv -----
module enms_ram #(
  parameter int WIDTH = enms_pkg::ENTRY_W,
  parameter int DEPTH = enms_pkg::MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int MAG_W         = enms_pkg::MAG_W;
  localparam int ANGLE_W       = enms_pkg::ANGLE_W;
  localparam int CFG_W         = enms_pkg::CFG_W;
  localparam int CFG_INDEX_W   = enms_pkg::CFG_INDEX_W;
  localparam int MAX_HEIGHT    = enms_pkg::MAX_HEIGHT;
  localparam int GAP_MAX       = 11;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int ROW_MAX       = enms_pkg::MAX_WIDTH_DEF;
  localparam int PIXEL_TARGET  = 800;

  // sector edges in binary angle units, 32768 = pi
  localparam int ANG_PI_8  = 4096;
  localparam int ANG_3PI_8 = 12288;
  localparam int ANG_5PI_8 = 20480;
  localparam int ANG_7PI_8 = 28672;

  class suppression_model;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [MAG_W-1:0]   upper_row [ROW_MAX];
    logic [MAG_W-1:0]   middle_row [ROW_MAX];
    logic [ANGLE_W-1:0] angle_row [ROW_MAX];
    logic [MAG_W-1:0]   win [9];
    logic [ANGLE_W-1:0] held_angle;
    int unsigned        col;
    int unsigned        row;
    int unsigned        emitted;
    enms_pkg::result_t  expected_q [$];
    int                 mismatches;
    int                 checked;

    function new();
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
        angle_row[i]  = '0;
      end
      foreach (win[i]) win[i] = '0;
      held_angle = '0;
      mismatches = 0;
      checked    = 0;
      restart();
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void restart();
      col     = 0;
      row     = 0;
      emitted = 0;
    endfunction

    function void write_reg(enms_pkg::cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == enms_pkg::REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
      restart();
    endfunction

    function logic [MAG_W-1:0] suppress(logic signed [ANGLE_W-1:0] a);
      int sa;
      logic [MAG_W-1:0] n1, n2;
      sa = a;
      if ((sa > -ANG_PI_8 && sa <= ANG_PI_8) || sa > ANG_7PI_8 || sa <= -ANG_7PI_8) begin
        n1 = win[1];
        n2 = win[7];
      end else if ((sa > -ANG_5PI_8 && sa <= -ANG_3PI_8) ||
                   (sa > ANG_3PI_8 && sa <= ANG_5PI_8)) begin
        n1 = win[3];
        n2 = win[5];
      end else if ((sa > -ANG_3PI_8 && sa <= -ANG_PI_8) ||
                   (sa > ANG_5PI_8 && sa <= ANG_7PI_8)) begin
        n1 = win[6];
        n2 = win[2];
      end else begin
        n1 = win[8];
        n2 = win[0];
      end
      if (win[4] < n1 || win[4] < n2) return '0;
      return win[4];
    endfunction

    function void note_beat(enms_pkg::op_t op, logic [MAG_W-1:0] mag,
                            logic [ANGLE_W-1:0] ang);
      int unsigned w, h, total, x, y, e;
      logic [MAG_W-1:0] up, mid;
      logic [ANGLE_W-1:0] ca;
      enms_pkg::result_t r;
      w = clamp(width_reg, ROW_MAX);
      h = clamp(height_reg, MAX_HEIGHT);
      total = w * h;
      if (op == enms_pkg::OP_PIXEL) begin
        if (row >= h || col >= w) restart();
        x = col;
        y = row;
        up  = upper_row[x];
        mid = middle_row[x];
        upper_row[x]  = mid;
        middle_row[x] = mag;
        for (int i = 0; i < 3; i++) begin
          win[3*i]   = win[3*i+1];
          win[3*i+1] = win[3*i+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = mag;
        ca = held_angle;
        held_angle = angle_row[x];
        angle_row[x] = ang;
        if (x + 1 >= w) begin
          col = 0;
          row = y + 1;
        end else begin
          col = x + 1;
        end
        if (y * w + x >= w + 1) begin
          r.magnitude_out = (x >= 2 && y >= 2) ? suppress(ca) : win[4];
          r.last = 1'b0;
          expected_q.push_back(r);
          emitted++;
        end
      end else begin
        e = emitted;
        // drop drains before the image is in or with nothing pending
        if (row >= h && e < total && e + w + 1 >= total) begin
          r.magnitude_out = (e + w + 1 == total) ? upper_row[w-1] : middle_row[e - (h-1)*w];
          r.last = (e + 1 == total);
          expected_q.push_back(r);
          emitted = e + 1;
          if (r.last) restart();
        end
      end
    endfunction

    function void check_beat(logic [MAG_W-1:0] mag, logic last);
      enms_pkg::result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d: mag %h last %b", checked, mag, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.magnitude_out !== mag || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d: expected mag %h last %b, got mag %h last %b",
                   checked, want.magnitude_out, want.last, mag, last);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  enms_pixel_if  pix_if ();
  enms_result_if res_if ();

  edge_non_maximum_suppression_top dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_if),
    .result    (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  suppression_model nms;
  bit send_calm;
  bit recv_calm;
  bit hold_request;
  int pixel_beats;
  int drain_beats;
  int sent_pixels;
  int images;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_if.valid && pix_if.ready) begin
        nms.note_beat(enms_pkg::op_t'(pix_if.op), pix_if.magnitude, pix_if.angle);
        if (pix_if.op == enms_pkg::OP_PIXEL) pixel_beats++;
        else drain_beats++;
      end
      if (res_if.valid && res_if.ready) nms.check_beat(res_if.magnitude_out, res_if.last);
    end
  end

  initial begin : receiver
    int gap;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        // hold off long enough for the block to back up its input
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  function automatic logic [MAG_W-1:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return MAG_W'($urandom_range(0, 3));
      default: return MAG_W'($urandom);
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_ang();
    int b;
    case ($urandom_range(0, 2))
      0: return ANGLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: b = ANG_PI_8;
          1: b = ANG_3PI_8;
          2: b = ANG_5PI_8;
          default: b = ANG_7PI_8;
        endcase
        if ($urandom_range(0, 1) == 1) b = -b;
        // land on, just below or just above a sector edge
        b = b + int'($urandom_range(0, 2)) - 1;
        return ANGLE_W'(b);
      end
      default: return ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic send_beat(enms_pkg::op_t op, logic [MAG_W-1:0] mag,
                           logic [ANGLE_W-1:0] ang);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid     <= 1'b1;
    pix_if.op        <= op;
    pix_if.magnitude <= mag;
    pix_if.angle     <= ang;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (nms.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(enms_pkg::cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    nms.write_reg(idx, val);
    reg_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
    wait_idle();
    write_cfg(enms_pkg::REG_IMAGE_WIDTH, w_raw);
    write_cfg(enms_pkg::REG_IMAGE_HEIGHT, h_raw);
  endtask

  task automatic send_image(int npix, int drains, int pause_at);
    for (int i = 0; i < npix; i++) begin
      if (i == pause_at) wait_idle();
      if ($urandom_range(0, 39) == 0)
        send_beat(enms_pkg::OP_DRAIN, MAG_W'($urandom), ANGLE_W'($urandom));
      send_beat(enms_pkg::OP_PIXEL, rand_mag(), rand_ang());
    end
    repeat (drains) send_beat(enms_pkg::OP_DRAIN, MAG_W'($urandom), ANGLE_W'($urandom));
    images++;
    sent_pixels += npix;
  endtask

  initial begin : stimulus
    logic [MAG_W-1:0]   dir_mag [9];
    logic [ANGLE_W-1:0] dir_ang [9];
    int cur_w, cur_h, w, h, npix, drains, pause_at, total_fails;
    nms = new();
    dir_mag = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF};
    dir_ang = '{16'h8000, 16'h7FFF, 16'h0000, 16'h1000, 16'h1001,
                16'hF000, 16'h3000, 16'h5000, 16'h7000};
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    hold_request = 1'b0;
    pixel_beats  = 0;
    drain_beats  = 0;
    sent_pixels  = 0;
    images       = 0;
    reg_writes   = 0;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= enms_pkg::REG_IMAGE_WIDTH;
    cfg_data         <= '0;
    pix_if.valid     <= 1'b0;
    pix_if.op        <= enms_pkg::OP_PIXEL;
    pix_if.magnitude <= '0;
    pix_if.angle     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // smallest image, extremes of magnitude and angle, centre loses to a diagonal
    set_size(11'd3, 11'd3);
    send_beat(enms_pkg::OP_DRAIN, '1, '1);
    for (int i = 0; i < 9; i++) send_beat(enms_pkg::OP_PIXEL, dir_mag[i], dir_ang[i]);
    // the last drain finds nothing pending
    repeat (5) send_beat(enms_pkg::OP_DRAIN, '0, '0);
    // clamped to 3x3; leave results behind for the next image to drop
    set_size(11'd2, 11'd1);
    send_image(9, 2, -1);
    cur_w = 3;
    cur_h = 3;

    while (sent_pixels < PIXEL_TARGET) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      if (images == 6) begin
        set_size(11'd12, 11'd8);
        cur_w = 12;
        cur_h = 8;
        hold_request = 1'b1;
        send_calm = 1'b1;
        send_image(96, 13, -1);
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
          h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(3, 6);
          set_size((w == 3) ? CFG_W'($urandom_range(0, 3)) : CFG_W'(w),
                   (h == 3) ? CFG_W'($urandom_range(0, 3)) : CFG_W'(h));
          cur_w = w;
          cur_h = h;
        end
        npix = cur_w * cur_h;
        drains = cur_w + 1;
        case ($urandom_range(0, 19))
          0: drains = $urandom_range(0, cur_w);
          1: drains += $urandom_range(1, 3);
          2: begin
            npix = $urandom_range(1, npix - 1);
            drains = 0;
          end
          default: ;
        endcase
        pause_at = (images % 50 == 9) ? npix / 2 : -1;
        send_image(npix, drains, pause_at);
      end
    end

    // register extremes clamped: first rows of a 1024-wide frame, top of a 1024-tall one
    send_calm = 1'b0;
    recv_calm = 1'b0;
    set_size(11'd2047, 11'd0);
    send_image(1040, 0, -1);
    set_size(11'd0, 11'd2047);
    send_image(60, 4, -1);

    wait_idle();
    repeat (20) @(posedge clk);
    total_fails = nms.mismatches + nms.expected_q.size();
    $display("Covered %0d images: %0d pixel and %0d drain beats, %0d results, %0d reg writes",
             images, pixel_beats, drain_beats, nms.checked, reg_writes);
    $display("Full frames 3x3 to 40x12, partial 1024-wide and 1024-tall frames, dropped tails,");
    $display("receiver hold-off and sender pause");
    if (total_fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/enms_pkg.sv
design/enms_if.sv
design/enms_ram.sv
design/edge_non_maximum_suppression_top.sv
tb/tb_top.sv
